/* hw/rtl/csb_pkg.sv */
// package for the cursor sequence buffer
// holds command codes, cell control types, state encoding and defaults
// no dependencies
`timescale 1ns / 1ps

package csb_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CMD_BITS       = 3;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_START   = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_ATTACH  = 3'd3,
        CMD_REMOVE  = 3'd4,
        CMD_QUERY   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP
    } t_stk_op;

    typedef struct packed {
        t_stk_op l_op;
        t_stk_op r_op;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/csb_cell.sv */
// one cell of the two-stack chain: one slot of the left stack and one of the right
// depends on csb_pkg
`timescale 1ns / 1ps

module csb_cell
    import csb_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [VALUE_BITS-1:0] i_l_prev,
    input  logic [VALUE_BITS-1:0] i_l_next,
    input  logic [VALUE_BITS-1:0] i_r_prev,
    input  logic [VALUE_BITS-1:0] i_r_next,
    output logic [VALUE_BITS-1:0] o_l,
    output logic [VALUE_BITS-1:0] o_r
);

    logic [VALUE_BITS-1:0] r_l, n_l;
    logic [VALUE_BITS-1:0] r_r, n_r;

    always_comb begin
        case (i_ctl.l_op)
            STK_PUSH: n_l = i_l_prev;
            STK_POP:  n_l = i_l_next;
            default:  n_l = r_l;
        endcase
    end

    always_comb begin
        case (i_ctl.r_op)
            STK_PUSH: n_r = i_r_prev;
            STK_POP:  n_r = i_r_next;
            default:  n_r = r_r;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_l <= n_l;
        r_r <= n_r;
    end

    assign o_l = r_l;
    assign o_r = r_r;

endmodule

/* hw/rtl/cursor_sequence_buffer_unit.sv */
// top level of the cursor sequence buffer: control, counts, result register, cell chain
// depends on csb_pkg and csb_cell
//
// channel  direction  signals
// in       to unit    i_in_valid, o_in_ready, i_command, i_value
// out      from unit  o_out_valid, i_out_ready, o_has_current, o_current_value,
//                     o_item_count, o_rejected
//
// items before the cursor sit in the left stack, the current item tops the right stack
// a command passes through idle, execute and done; execute repeats while rewinding, done waits for a free output
// the result register loads as the command leaves done; a new transfer is taken only in idle
// start, and insert with no current item, stay in execute while items remain before the cursor
// (the rewind moves one item from the left to the right stack per cycle)
// a new command is taken while the previous result waits; a stalled output holds execution
// reset clears the state, counts, reject flag and output valid but not the cells, so no clearing pass is needed
`timescale 1ns / 1ps

module cursor_sequence_buffer_unit
    import csb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_BITS-1:0]   i_command,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_has_current,
    output logic [VALUE_BITS-1:0] o_current_value,
    output logic [CNT_W-1:0]      o_item_count,
    output logic                  o_rejected
);

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_front;
    logic [CNT_W-1:0]      r_nl, n_nl;
    logic [CNT_W-1:0]      r_nr, n_nr;
    logic                  r_rej, n_rej;

    logic                  r_out_valid;
    logic                  r_out_has;
    logic [VALUE_BITS-1:0] r_out_cur;
    logic [CNT_W-1:0]      r_out_cnt;
    logic                  r_out_rej;

    logic [CNT_W-1:0]      w_count;
    logic                  w_full;
    logic                  w_rewind;
    logic                  w_out_free;
    logic                  w_in_xfer;
    t_cell_ctl             w_ctl0;
    t_cell_ctl             w_ctl_rest;
    logic [VALUE_BITS-1:0] w_r_in;
    logic [VALUE_BITS-1:0] w_l [DEPTH];
    logic [VALUE_BITS-1:0] w_r [DEPTH];

    assign w_count    = CNT_W'(r_nl + r_nr);
    assign w_full     = (w_count == CNT_W'(DEPTH));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_rewind   = (r_nl != '0) && r_front;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_in_xfer) n_state = ST_EXEC;
            ST_EXEC: if (!w_rewind) n_state = ST_DONE;
            ST_DONE: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // stack control and counts
    always_comb begin
        w_ctl0     = '{l_op: STK_HOLD, r_op: STK_HOLD};
        w_ctl_rest = '{l_op: STK_HOLD, r_op: STK_HOLD};
        w_r_in     = r_val;
        n_nl       = r_nl;
        n_nr       = r_nr;
        n_rej      = r_rej;
        if (r_state == ST_EXEC) begin
            n_rej = 1'b0;
            if (w_rewind) begin
                w_ctl0     = '{l_op: STK_POP, r_op: STK_PUSH};
                w_ctl_rest = '{l_op: STK_POP, r_op: STK_PUSH};
                w_r_in     = w_l[0];
                n_nl       = r_nl - CNT_W'(1);
                n_nr       = r_nr + CNT_W'(1);
            end else begin
                case (r_cmd)
                    CMD_ADVANCE: begin
                        if (r_nr != '0) begin
                            w_ctl0     = '{l_op: STK_PUSH, r_op: STK_POP};
                            w_ctl_rest = '{l_op: STK_PUSH, r_op: STK_POP};
                            n_nl       = r_nl + CNT_W'(1);
                            n_nr       = r_nr - CNT_W'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (w_full) begin
                            n_rej = 1'b1;
                        end else begin
                            w_ctl0     = '{l_op: STK_HOLD, r_op: STK_PUSH};
                            w_ctl_rest = '{l_op: STK_HOLD, r_op: STK_PUSH};
                            n_nr       = r_nr + CNT_W'(1);
                        end
                    end
                    CMD_ATTACH: begin
                        if (w_full) begin
                            n_rej = 1'b1;
                        end else if (r_nr == '0) begin
                            w_ctl0     = '{l_op: STK_HOLD, r_op: STK_PUSH};
                            w_ctl_rest = '{l_op: STK_HOLD, r_op: STK_PUSH};
                            n_nr       = r_nr + CNT_W'(1);
                        end else begin
                            // current moves left, new value replaces the right top
                            w_ctl0     = '{l_op: STK_PUSH, r_op: STK_PUSH};
                            w_ctl_rest = '{l_op: STK_PUSH, r_op: STK_HOLD};
                            n_nl       = r_nl + CNT_W'(1);
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_nr != '0) begin
                            w_ctl0     = '{l_op: STK_HOLD, r_op: STK_POP};
                            w_ctl_rest = '{l_op: STK_HOLD, r_op: STK_POP};
                            n_nr       = r_nr - CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nl        <= '0;
            r_nr        <= '0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_nl    <= n_nl;
            r_nr    <= n_nr;
            r_rej   <= n_rej;
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd   <= t_cmd'(i_command);
            r_val   <= i_value;
            // rewind to the front for start, and for insert with no current item
            r_front <= (i_command == CMD_START) ||
                       ((i_command == CMD_INSERT) && !w_full && (r_nr == '0));
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_has <= (r_nr != '0);
            r_out_cur <= (r_nr != '0) ? w_r[0] : '0;
            r_out_cnt <= w_count;
            r_out_rej <= r_rej;
        end
    end

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_l_prev, w_l_next, w_r_prev, w_r_next;
        t_cell_ctl             w_ctl;
        if (g == 0) begin : g_head
            assign w_l_prev = w_r[0];
            assign w_r_prev = w_r_in;
            assign w_ctl    = w_ctl0;
        end else begin : g_body
            assign w_l_prev = w_l[g-1];
            assign w_r_prev = w_r[g-1];
            assign w_ctl    = w_ctl_rest;
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_l_next = '0;
            assign w_r_next = '0;
        end else begin : g_link
            assign w_l_next = w_l[g+1];
            assign w_r_next = w_r[g+1];
        end
        csb_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_l_prev (w_l_prev),
            .i_l_next (w_l_next),
            .i_r_prev (w_r_prev),
            .i_r_next (w_r_next),
            .o_l      (w_l[g]),
            .o_r      (w_r[g])
        );
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_has_current   = r_out_has;
    assign o_current_value = r_out_cur;
    assign o_item_count    = r_out_cnt;
    assign o_rejected      = r_out_rej;

endmodule

/* hw/rtl/csb_checker.sv */
// port-level checks for the cursor sequence buffer, bound to the top level
// depends on csb_pkg and cursor_sequence_buffer_unit
`timescale 1ns / 1ps

module csb_checker
    import csb_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_ready,
    input logic                  o_out_valid,
    input logic                  o_has_current,
    input logic [VALUE_BITS-1:0] o_current_value,
    input logic [CNT_W-1:0]      o_item_count,
    input logic                  o_rejected
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_item_count)
            && $stable(o_current_value) && $stable(o_rejected))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_item_count <= CNT_W'(DEPTH))
        else $error("item count above depth");

    a_no_current_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_current |-> o_current_value == '0)
        else $error("value shown without current item");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_item_count == CNT_W'(DEPTH) && o_has_current == 1'b0
            || o_out_valid && o_rejected && o_item_count == CNT_W'(DEPTH))
        else $error("reject without full store");

    a_current_needs_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_current |-> o_item_count != '0)
        else $error("current item in empty store");

endmodule

bind cursor_sequence_buffer_unit csb_checker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
) u_csb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_ready     (i_out_ready),
    .o_out_valid     (o_out_valid),
    .o_has_current   (o_has_current),
    .o_current_value (o_current_value),
    .o_item_count    (o_item_count),
    .o_rejected      (o_rejected)
);
